>>> rtl/armv4t_data_processing_alu_macros.svh
// Assertion helpers for the data-processing ALU.
// Each macro takes a label, the clock, the reset, a property expression and a message.
`ifndef ARMV4T_DATA_PROCESSING_ALU_MACROS_SVH
`define ARMV4T_DATA_PROCESSING_ALU_MACROS_SVH

`ifndef SYNTHESIS
`define ADPALU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ADPALU_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ADPALU_ASSERT(lbl, clk, rst, prop, msg)
`define ADPALU_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

>>> rtl/adpalu_pkg.sv
package adpalu_pkg;

   // Data-processing opcodes
   typedef enum logic [3:0] {
      OP_AND = 4'd0,
      OP_EOR = 4'd1,
      OP_SUB = 4'd2,
      OP_RSB = 4'd3,
      OP_ADD = 4'd4,
      OP_ADC = 4'd5,
      OP_SBC = 4'd6,
      OP_RSC = 4'd7,
      OP_TST = 4'd8,
      OP_TEQ = 4'd9,
      OP_CMP = 4'd10,
      OP_CMN = 4'd11,
      OP_ORR = 4'd12,
      OP_MOV = 4'd13,
      OP_BIC = 4'd14,
      OP_MVN = 4'd15
   } alu_op_type;

   // Condition codes
   typedef enum logic [3:0] {
      COND_EQ = 4'd0,
      COND_NE = 4'd1,
      COND_CS = 4'd2,
      COND_CC = 4'd3,
      COND_MI = 4'd4,
      COND_PL = 4'd5,
      COND_VS = 4'd6,
      COND_VC = 4'd7,
      COND_HI = 4'd8,
      COND_LS = 4'd9,
      COND_GE = 4'd10,
      COND_LT = 4'd11,
      COND_GT = 4'd12,
      COND_LE = 4'd13,
      COND_AL = 4'd14,
      COND_NV = 4'd15
   } cond_type;

   // Shifter operations
   typedef enum logic [1:0] {
      SHIFT_LSL = 2'd0,
      SHIFT_LSR = 2'd1,
      SHIFT_ASR = 2'd2,
      SHIFT_ROR = 2'd3
   } shift_op_type;

   // Second-operand modes; code 3 behaves as rotated immediate
   localparam logic [1:0] MODE_IMM_SHIFT = 2'd0;
   localparam logic [1:0] MODE_REG_SHIFT = 2'd1;
   localparam logic [1:0] MODE_ROT_IMM   = 2'd2;

   // Flag bit positions in the NZCV nibble
   localparam int FLAG_N = 3;
   localparam int FLAG_Z = 2;
   localparam int FLAG_C = 1;
   localparam int FLAG_V = 0;

   // Shifter controls
   typedef struct packed {
      logic [1:0]   mode;
      shift_op_type op;
      logic [7:0]   amount;
   } shift_ctrl_type;

   // Registered input word
   typedef struct packed {
      alu_op_type     operation;
      cond_type       condition;
      logic [31:0]    operand_a;
      logic [31:0]    operand_b;
      shift_ctrl_type shift;
      logic           set_flags;
      logic [3:0]     flags_in;
   } req_word_type;

   // Condition test against NZCV
   function automatic logic cond_holds(input cond_type cond, input logic [3:0] flags);
      logic n, z, c, v, ok;
      n = flags[FLAG_N];
      z = flags[FLAG_Z];
      c = flags[FLAG_C];
      v = flags[FLAG_V];
      case (cond)
         COND_EQ: ok = z;
         COND_NE: ok = !z;
         COND_CS: ok = c;
         COND_CC: ok = !c;
         COND_MI: ok = n;
         COND_PL: ok = !n;
         COND_VS: ok = v;
         COND_VC: ok = !v;
         COND_HI: ok = c && !z;
         COND_LS: ok = !c || z;
         COND_GE: ok = (n == v);
         COND_LT: ok = (n != v);
         COND_GT: ok = !z && (n == v);
         COND_LE: ok = z || (n != v);
         COND_AL: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

>>> rtl/adpalu_if.sv
// Operation word channel
interface adpalu_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  operation;
   logic [3:0]  condition;
   logic [31:0] operand_a;
   logic [31:0] operand_b;
   logic [1:0]  operand_mode;
   logic [1:0]  shift_type;
   logic [7:0]  shift_amount;
   logic        set_flags;
   logic [3:0]  flags_in;

   modport source (
      output valid, operation, condition, operand_a, operand_b, operand_mode,
             shift_type, shift_amount, set_flags, flags_in,
      input  ready
   );
   modport sink (
      input  valid, operation, condition, operand_a, operand_b, operand_mode,
             shift_type, shift_amount, set_flags, flags_in,
      output ready
   );
endinterface

// Result word channel
interface adpalu_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_value;
   logic        write_back;
   logic [3:0]  flags_out;
   logic        condition_passed;

   modport source (
      output valid, result_value, write_back, flags_out, condition_passed,
      input  ready
   );
   modport sink (
      input  valid, result_value, write_back, flags_out, condition_passed,
      output ready
   );
endinterface

>>> rtl/adpalu_shifter.sv
// Barrel shifter for the second operand
module adpalu_shifter (
   input  logic                       [31:0] operand_b,
   input  adpalu_pkg::shift_ctrl_type        ctrl,
   input  logic                              carry_in,
   output logic                       [31:0] shifted,
   output logic                              carry_out
);

   logic               rot_imm;
   logic               keep;
   logic               rrx;
   logic [7:0]         eff_amt;
   logic               big;
   logic [32:0]        lsl_t;
   logic [32:0]        lsr_t;
   logic signed [32:0] asr_t;
   logic [4:0]         rot_amt;
   logic [31:0]        rot_src;
   logic [63:0]        rot_wide;
   logic [31:0]        rotated;

   // Effective count: immediate #0 encodings, register count as is
   always_comb begin
      rot_imm = ctrl.mode[1];
      keep    = 1'b0;
      rrx     = 1'b0;
      eff_amt = ctrl.amount;
      if (ctrl.mode == adpalu_pkg::MODE_IMM_SHIFT) begin
         eff_amt = {3'b000, ctrl.amount[4:0]};
         if (ctrl.amount[4:0] == 5'd0) begin
            if (ctrl.op == adpalu_pkg::SHIFT_LSL) begin
               keep = 1'b1;
            end else if (ctrl.op == adpalu_pkg::SHIFT_ROR) begin
               rrx = 1'b1;
            end else begin
               eff_amt = 8'd32;
            end
         end
      end else begin
         keep = (ctrl.amount == 8'd0);
      end
   end

   // Raw shift results, carry rides in the extra bit
   always_comb begin
      big      = (eff_amt > 8'd32);
      lsl_t    = {1'b0, operand_b} << eff_amt[5:0];
      lsr_t    = {operand_b, 1'b0} >> eff_amt[5:0];
      asr_t    = $signed({operand_b, 1'b0}) >>> eff_amt[4:0];
      rot_amt  = rot_imm ? ctrl.amount[4:0] : eff_amt[4:0];
      rot_src  = rot_imm ? {24'd0, operand_b[7:0]} : operand_b;
      rot_wide = {rot_src, rot_src} >> rot_amt;
      rotated  = rot_wide[31:0];
   end

   // Output select
   always_comb begin
      shifted   = operand_b;
      carry_out = carry_in;
      if (rot_imm) begin
         shifted = rotated;
         if (ctrl.amount != 8'd0) begin
            carry_out = rotated[31];
         end
      end else if (rrx) begin
         shifted   = {carry_in, operand_b[31:1]};
         carry_out = operand_b[0];
      end else if (!keep) begin
         case (ctrl.op)
            adpalu_pkg::SHIFT_LSL: begin
               shifted   = big ? 32'd0 : lsl_t[31:0];
               carry_out = big ? 1'b0 : lsl_t[32];
            end
            adpalu_pkg::SHIFT_LSR: begin
               shifted   = big ? 32'd0 : lsr_t[32:1];
               carry_out = big ? 1'b0 : lsr_t[0];
            end
            adpalu_pkg::SHIFT_ASR: begin
               if (eff_amt >= 8'd32) begin
                  shifted   = {32{operand_b[31]}};
                  carry_out = operand_b[31];
               end else begin
                  shifted   = asr_t[32:1];
                  carry_out = asr_t[0];
               end
            end
            adpalu_pkg::SHIFT_ROR: begin
               shifted   = rotated;
               carry_out = rotated[31];
            end
            default: begin
               shifted   = operand_b;
               carry_out = carry_in;
            end
         endcase
      end
   end

endmodule

>>> rtl/armv4t_data_processing_alu.sv
// Channel | Dir | Word contents
// req_if  | in  | operation, condition, operand_a, operand_b, operand_mode,
//         |     | shift_type, shift_amount, set_flags, flags_in
// rsp_if  | out | result_value, write_back, flags_out, condition_passed
//
// One word per cycle while results are taken; a word passes stage 1, then the result register.
// Stage 1 is the input register; the shifter, adder and flag logic sit
// between it and the result register.
// Synchronous active-high reset empties both stages.
// A stalled result holds in the result register while stage 1 still fills.
`include "armv4t_data_processing_alu_macros.svh"

module armv4t_data_processing_alu (
   input  logic          clock,
   input  logic          reset,
   adpalu_req_if.sink    req_if,
   adpalu_rsp_if.source  rsp_if
);

   logic                     s1_valid_ff, s1_valid_in;
   adpalu_pkg::req_word_type s1_word_ff, s1_word_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [31:0]              rsp_result_ff, rsp_result_in;
   logic                     rsp_write_back_ff, rsp_write_back_in;
   logic [3:0]               rsp_flags_ff, rsp_flags_in;
   logic                     rsp_passed_ff, rsp_passed_in;

   logic        rsp_move;
   logic        req_take;
   logic        passed;
   logic [31:0] op_b;
   logic        shift_carry;
   logic [31:0] add_x, add_y;
   logic        add_cin;
   logic [32:0] add_sum;
   logic        add_v;
   logic [31:0] res;
   logic        logical;
   logic        compare;
   logic        new_c, new_v;
   logic [3:0]  flags_new;

   // Handshake: result register frees when empty or taken
   assign rsp_move     = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = !s1_valid_ff || rsp_move;
   assign req_take     = req_if.valid && req_if.ready;

   // Input register
   always_comb begin
      s1_valid_in = req_if.ready ? req_if.valid : s1_valid_ff;
      s1_word_in  = s1_word_ff;
      if (req_take) begin
         s1_word_in.operation    = adpalu_pkg::alu_op_type'(req_if.operation);
         s1_word_in.condition    = adpalu_pkg::cond_type'(req_if.condition);
         s1_word_in.operand_a    = req_if.operand_a;
         s1_word_in.operand_b    = req_if.operand_b;
         s1_word_in.shift.mode   = req_if.operand_mode;
         s1_word_in.shift.op     = adpalu_pkg::shift_op_type'(req_if.shift_type);
         s1_word_in.shift.amount = req_if.shift_amount;
         s1_word_in.set_flags    = req_if.set_flags;
         s1_word_in.flags_in     = req_if.flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_word_ff <= s1_word_in;
   end

   // Second operand through the shifter
   adpalu_shifter u_shifter (
      .operand_b (s1_word_ff.operand_b),
      .ctrl      (s1_word_ff.shift),
      .carry_in  (s1_word_ff.flags_in[adpalu_pkg::FLAG_C]),
      .shifted   (op_b),
      .carry_out (shift_carry)
   );

   assign passed = adpalu_pkg::cond_holds(s1_word_ff.condition, s1_word_ff.flags_in);

   // Opcode decode: adder inputs or logical result
   always_comb begin
      add_x   = s1_word_ff.operand_a;
      add_y   = op_b;
      add_cin = 1'b0;
      res     = 32'd0;
      logical = 1'b1;
      compare = 1'b0;
      case (s1_word_ff.operation)
         adpalu_pkg::OP_AND: res = s1_word_ff.operand_a & op_b;
         adpalu_pkg::OP_EOR: res = s1_word_ff.operand_a ^ op_b;
         adpalu_pkg::OP_TST: begin
            res     = s1_word_ff.operand_a & op_b;
            compare = 1'b1;
         end
         adpalu_pkg::OP_TEQ: begin
            res     = s1_word_ff.operand_a ^ op_b;
            compare = 1'b1;
         end
         adpalu_pkg::OP_SUB: begin
            add_y   = ~op_b;
            add_cin = 1'b1;
            logical = 1'b0;
         end
         adpalu_pkg::OP_CMP: begin
            add_y   = ~op_b;
            add_cin = 1'b1;
            logical = 1'b0;
            compare = 1'b1;
         end
         adpalu_pkg::OP_RSB: begin
            add_x   = op_b;
            add_y   = ~s1_word_ff.operand_a;
            add_cin = 1'b1;
            logical = 1'b0;
         end
         adpalu_pkg::OP_ADD: logical = 1'b0;
         adpalu_pkg::OP_CMN: begin
            logical = 1'b0;
            compare = 1'b1;
         end
         adpalu_pkg::OP_ADC: begin
            add_cin = s1_word_ff.flags_in[adpalu_pkg::FLAG_C];
            logical = 1'b0;
         end
         adpalu_pkg::OP_SBC: begin
            add_y   = ~op_b;
            add_cin = s1_word_ff.flags_in[adpalu_pkg::FLAG_C];
            logical = 1'b0;
         end
         adpalu_pkg::OP_RSC: begin
            add_x   = op_b;
            add_y   = ~s1_word_ff.operand_a;
            add_cin = s1_word_ff.flags_in[adpalu_pkg::FLAG_C];
            logical = 1'b0;
         end
         adpalu_pkg::OP_ORR: res = s1_word_ff.operand_a | op_b;
         adpalu_pkg::OP_MOV: res = op_b;
         adpalu_pkg::OP_BIC: res = s1_word_ff.operand_a & ~op_b;
         adpalu_pkg::OP_MVN: res = ~op_b;
         default:            res = ~op_b;
      endcase
   end

   // Adder with carry and overflow
   assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};
   assign add_v   = ~(add_x[31] ^ add_y[31]) & (add_x[31] ^ add_sum[31]);

   // Flags
   always_comb begin
      new_c = logical ? shift_carry : add_sum[32];
      new_v = logical ? s1_word_ff.flags_in[adpalu_pkg::FLAG_V] : add_v;
      if (logical) begin
         flags_new = {res[31], (res == 32'd0), new_c, new_v};
      end else begin
         flags_new = {add_sum[31], (add_sum[31:0] == 32'd0), new_c, new_v};
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in      = rsp_move ? s1_valid_ff : rsp_valid_ff;
      rsp_result_in     = rsp_result_ff;
      rsp_write_back_in = rsp_write_back_ff;
      rsp_flags_in      = rsp_flags_ff;
      rsp_passed_in     = rsp_passed_ff;
      if (s1_valid_ff && rsp_move) begin
         rsp_passed_in = passed;
         if (!passed) begin
            rsp_result_in     = 32'd0;
            rsp_write_back_in = 1'b0;
            rsp_flags_in      = s1_word_ff.flags_in;
         end else begin
            rsp_result_in     = logical ? res : add_sum[31:0];
            rsp_write_back_in = !compare;
            rsp_flags_in      = s1_word_ff.set_flags ? flags_new : s1_word_ff.flags_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_result_ff     <= rsp_result_in;
      rsp_write_back_ff <= rsp_write_back_in;
      rsp_flags_ff      <= rsp_flags_in;
      rsp_passed_ff     <= rsp_passed_in;
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.result_value     = rsp_result_ff;
   assign rsp_if.write_back       = rsp_write_back_ff;
   assign rsp_if.flags_out        = rsp_flags_ff;
   assign rsp_if.condition_passed = rsp_passed_ff;

   // Checks
   `ADPALU_ASSERT(a_rsp_has_source, clock, reset, rsp_valid_ff |-> ($past(s1_valid_ff) || $past(rsp_valid_ff)), "result word without a source")
   `ADPALU_ASSERT(a_s1_held, clock, reset, (s1_valid_ff && !rsp_move) |=> s1_valid_ff, "stage 1 word dropped while stalled")
   `ADPALU_ASSERT_NEVER(a_wb_needs_pass, clock, reset, rsp_valid_ff && rsp_write_back_ff && !rsp_passed_ff, "write back on failed condition")
   `ADPALU_ASSERT_NEVER(a_fail_zero, clock, reset, rsp_valid_ff && !rsp_passed_ff && (rsp_result_ff != 32'd0), "failed condition with nonzero result")
   `ADPALU_ASSERT_NEVER(a_nv_fails, clock, reset, s1_valid_ff && (s1_word_ff.condition == adpalu_pkg::COND_NV) && passed, "never condition passed")

endmodule

>>> tb/armv4t_data_processing_alu_tb.sv
module armv4t_data_processing_alu_tb;
   import adpalu_pkg::*;

   localparam int RANDOM_WORDS   = 825;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int LONG_HOLD      = 80;

   // One result word as the ALU produces it
   typedef struct packed {
      logic [31:0] value;
      logic        write_back;
      logic [3:0]  flags;
      logic        passed;
   } alu_result_type;

   logic clock;
   logic reset;

   adpalu_req_if req_ch ();
   adpalu_rsp_if rsp_ch ();

   armv4t_data_processing_alu dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   req_word_type   pending_words[$];
   alu_result_type expected_results[$];

   int          words_sent;
   int          results_checked;
   int          cond_fail_count;
   int          long_holds;
   int          error_count;
   int unsigned idle_cycles;

   // Driver burst state
   int unsigned burst_left;
   int unsigned gap_left;

   // Receiver stall state
   int unsigned hold_left;
   int unsigned pattern_left;
   int unsigned stall_style;
   int          next_long_hold;

   always #5 clock = ~clock;

   // Condition test; bit 0 of the code inverts the base test (AL/NV pair too)
   function automatic logic condition_met(input cond_type cc, input logic [3:0] fl);
      logic n, z, c, v, hit;
      n = fl[FLAG_N];
      z = fl[FLAG_Z];
      c = fl[FLAG_C];
      v = fl[FLAG_V];
      case (cc)
         COND_EQ, COND_NE: hit = z;
         COND_CS, COND_CC: hit = c;
         COND_MI, COND_PL: hit = n;
         COND_VS, COND_VC: hit = v;
         COND_HI, COND_LS: hit = c && !z;
         COND_GE, COND_LT: hit = (n == v);
         COND_GT, COND_LE: hit = !z && (n == v);
         default:          hit = 1'b1;
      endcase
      return cc[0] ? !hit : hit;
   endfunction

   function automatic logic [31:0] rotate_right(input logic [31:0] v, input int unsigned r);
      logic [63:0] both;
      both = {v, v} >> (r % 32);
      return both[31:0];
   endfunction

   // Barrel shifter on operand b; returns {carry out, shifted value}
   function automatic logic [32:0] shift_operand_b(input req_word_type w);
      logic [31:0] val;
      logic        cout;
      int unsigned cnt;
      val  = w.operand_b;
      cout = w.flags_in[FLAG_C];
      if (w.shift.mode >= MODE_ROT_IMM) begin
         val = rotate_right({24'd0, val[7:0]}, 32'(w.shift.amount));
         if (w.shift.amount != 0) cout = val[31];
         return {cout, val};
      end
      if (w.shift.mode == MODE_IMM_SHIFT) begin
         cnt = 32'(w.shift.amount[4:0]);
         // #0 encodings: LSL #0 is a plain move, ROR #0 is RRX, LSR/ASR #0 mean #32
         if (cnt == 0) begin
            if (w.shift.op == SHIFT_LSL) return {cout, val};
            if (w.shift.op == SHIFT_ROR) return {val[0], cout, val[31:1]};
            cnt = 32;
         end
      end else begin
         cnt = 32'(w.shift.amount);
      end
      if (cnt == 0) return {cout, val};
      case (w.shift.op)
         SHIFT_LSL: begin
            cout = (cnt <= 32) ? val[32 - cnt] : 1'b0;
            val  = (cnt < 32) ? val << cnt : 32'd0;
         end
         SHIFT_LSR: begin
            cout = (cnt <= 32) ? val[cnt - 1] : 1'b0;
            val  = (cnt < 32) ? val >> cnt : 32'd0;
         end
         SHIFT_ASR: begin
            if (cnt >= 32) begin
               cout = val[31];
               val  = {32{val[31]}};
            end else begin
               cout = val[cnt - 1];
               val  = $signed(val) >>> cnt;
            end
         end
         default: begin
            val  = rotate_right(val, cnt);
            cout = val[31];
         end
      endcase
      return {cout, val};
   endfunction

   // 32-bit add; returns {carry, overflow, sum}
   function automatic logic [33:0] add_carry_ovf(input logic [31:0] x, input logic [31:0] y,
                                                 input logic cin);
      logic [32:0] total;
      total = {1'b0, x} + {1'b0, y} + {32'd0, cin};
      return {total[32], (x[31] == y[31]) && (total[31] != x[31]), total[31:0]};
   endfunction

   // Expected result word for one operation word
   function automatic alu_result_type predict_result(input req_word_type w);
      alu_result_type res;
      logic [31:0] a, b, r;
      logic        sc, nc, nv, cin, logical;
      cin            = w.flags_in[FLAG_C];
      res.value      = '0;
      res.write_back = 1'b0;
      res.flags      = w.flags_in;
      res.passed     = 1'b0;
      if (!condition_met(w.condition, w.flags_in)) return res;
      a       = w.operand_a;
      {sc, b} = shift_operand_b(w);
      nc      = cin;
      nv      = w.flags_in[FLAG_V];
      logical = 1'b0;
      r       = '0;
      case (w.operation)
         OP_AND, OP_TST: begin
            r = a & b;
            logical = 1'b1;
         end
         OP_EOR, OP_TEQ: begin
            r = a ^ b;
            logical = 1'b1;
         end
         OP_SUB, OP_CMP: {nc, nv, r} = add_carry_ovf(a, ~b, 1'b1);
         OP_RSB:         {nc, nv, r} = add_carry_ovf(b, ~a, 1'b1);
         OP_ADD, OP_CMN: {nc, nv, r} = add_carry_ovf(a, b, 1'b0);
         OP_ADC:         {nc, nv, r} = add_carry_ovf(a, b, cin);
         OP_SBC:         {nc, nv, r} = add_carry_ovf(a, ~b, cin);
         OP_RSC:         {nc, nv, r} = add_carry_ovf(b, ~a, cin);
         OP_ORR: begin
            r = a | b;
            logical = 1'b1;
         end
         OP_MOV: begin
            r = b;
            logical = 1'b1;
         end
         OP_BIC: begin
            r = a & ~b;
            logical = 1'b1;
         end
         default: begin
            r = ~b;
            logical = 1'b1;
         end
      endcase
      // logical ops take C from the shifter and keep V
      if (logical) nc = sc;
      if (w.set_flags) res.flags = {r[31], r == 32'd0, nc, nv};
      res.value      = r;
      res.write_back = !(w.operation inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN});
      res.passed     = 1'b1;
      return res;
   endfunction

   function automatic req_word_type make_word(input alu_op_type op, input cond_type cc,
                                              input logic [31:0] a, input logic [31:0] b,
                                              input logic [1:0] mode, input shift_op_type sh,
                                              input logic [7:0] amt, input logic sf,
                                              input logic [3:0] fl);
      req_word_type w;
      w.operation    = op;
      w.condition    = cc;
      w.operand_a    = a;
      w.operand_b    = b;
      w.shift.mode   = mode;
      w.shift.op     = sh;
      w.shift.amount = amt;
      w.set_flags    = sf;
      w.flags_in     = fl;
      return w;
   endfunction

   // Operand values biased toward the adder and shifter corners
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         4:       return $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   // Operation word driver: bursts of random length separated by random gaps
   always @(posedge clock) begin : op_driver
      logic         offer;
      logic         hold;
      req_word_type nxt;
      offer = 1'b0;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         hold = req_ch.valid && !req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            expected_results.push_back(predict_result(pending_words.pop_front()));
            words_sent++;
         end
         if (!hold) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (pending_words.size() != 0) begin
               offer = 1'b1;
               if (burst_left == 0)
                  burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                            : $urandom_range(1, 16);
               burst_left--;
               if (burst_left == 0)
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
         if (offer) begin
            nxt = pending_words[0];
            req_ch.operation    <= nxt.operation;
            req_ch.condition    <= nxt.condition;
            req_ch.operand_a    <= nxt.operand_a;
            req_ch.operand_b    <= nxt.operand_b;
            req_ch.operand_mode <= nxt.shift.mode;
            req_ch.shift_type   <= nxt.shift.op;
            req_ch.shift_amount <= nxt.shift.amount;
            req_ch.set_flags    <= nxt.set_flags;
            req_ch.flags_in     <= nxt.flags_in;
         end
         req_ch.valid <= hold || offer;
      end
   end

   // Result monitor and receiver stall pattern
   always @(posedge clock) begin : rsp_monitor
      logic           give;
      alu_result_type got;
      alu_result_type want;
      give = 1'b1;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.value      = rsp_ch.result_value;
            got.write_back = rsp_ch.write_back;
            got.flags      = rsp_ch.flags_out;
            got.passed     = rsp_ch.condition_passed;
            if (expected_results.size() == 0) begin
               $error("result word with nothing pending: result_value %h", got.value);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.value !== want.value) begin
                  $error("result_value: expected %h, got %h", want.value, got.value);
                  error_count++;
               end
               if (got.write_back !== want.write_back) begin
                  $error("write_back: expected %b, got %b", want.write_back, got.write_back);
                  error_count++;
               end
               if (got.flags !== want.flags) begin
                  $error("flags_out: expected %b, got %b", want.flags, got.flags);
                  error_count++;
               end
               if (got.passed !== want.passed) begin
                  $error("condition_passed: expected %b, got %b", want.passed, got.passed);
                  error_count++;
               end
               if (!want.passed) cond_fail_count++;
            end
            results_checked++;
         end
         // long hold-offs let the pipeline fill and back up into the input
         if (hold_left != 0) begin
            hold_left--;
            give = 1'b0;
         end else if (results_checked >= next_long_hold) begin
            next_long_hold += 350;
            hold_left = LONG_HOLD - 1;
            long_holds++;
            give = 1'b0;
         end else begin
            if (pattern_left == 0) begin
               stall_style  = $urandom_range(0, 3);
               pattern_left = $urandom_range(16, 96);
            end
            pattern_left--;
            case (stall_style)
               0:       give = 1'b1;
               1:       give = 1'($urandom_range(0, 1));
               2:       give = ($urandom_range(0, 4) != 0);
               default: give = ($urandom_range(0, 3) == 0);
            endcase
         end
         rsp_ch.ready <= give;
      end
   end

   // Cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      req_word_type w;
      clock               = 1'b0;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.operation    = '0;
      req_ch.condition    = '0;
      req_ch.operand_a    = '0;
      req_ch.operand_b    = '0;
      req_ch.operand_mode = '0;
      req_ch.shift_type   = '0;
      req_ch.shift_amount = '0;
      req_ch.set_flags    = 1'b0;
      req_ch.flags_in     = '0;
      rsp_ch.ready        = 1'b0;
      words_sent          = 0;
      results_checked     = 0;
      cond_fail_count     = 0;
      long_holds          = 0;
      error_count         = 0;
      idle_cycles         = 0;
      burst_left          = 0;
      gap_left            = 0;
      hold_left           = 0;
      pattern_left        = 0;
      stall_style         = 0;
      next_long_hold      = 300;

      // Directed words: every opcode, operand extremes, shifter encodings, conditions
      pending_words.push_back(make_word(OP_AND, COND_AL, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        MODE_IMM_SHIFT, SHIFT_LSL, 8'd0, 1'b1, 4'h0));
      // LSR #0 means LSR #32
      pending_words.push_back(make_word(OP_EOR, COND_AL, 32'h0, 32'h8000_0000,
                                        MODE_IMM_SHIFT, SHIFT_LSR, 8'd0, 1'b1, 4'hF));
      pending_words.push_back(make_word(OP_SUB, COND_AL, 32'h0, 32'h1,
                                        MODE_IMM_SHIFT, SHIFT_LSL, 8'd0, 1'b1, 4'h0));
      // ASR #0 means ASR #32
      pending_words.push_back(make_word(OP_RSB, COND_AL, 32'h1, 32'h7FFF_FFFF,
                                        MODE_IMM_SHIFT, SHIFT_ASR, 8'd0, 1'b1, 4'h0));
      pending_words.push_back(make_word(OP_ADD, COND_AL, 32'h7FFF_FFFF, 32'h1,
                                        MODE_IMM_SHIFT, SHIFT_LSL, 8'd0, 1'b1, 4'h0));
      pending_words.push_back(make_word(OP_ADC, COND_AL, 32'hFFFF_FFFF, 32'h0,
                                        MODE_IMM_SHIFT, SHIFT_LSL, 8'd0, 1'b1, 4'h2));
      pending_words.push_back(make_word(OP_SBC, COND_AL, 32'h8000_0000, 32'h1,
                                        MODE_IMM_SHIFT, SHIFT_LSL, 8'd0, 1'b1, 4'h0));
      pending_words.push_back(make_word(OP_RSC, COND_AL, 32'h0, 32'h0,
                                        MODE_IMM_SHIFT, SHIFT_LSL, 8'd0, 1'b1, 4'h2));
      // test/compare without set_flags: no write-back, flags untouched
      pending_words.push_back(make_word(OP_TST, COND_AL, 32'hF, 32'hF0,
                                        MODE_ROT_IMM, SHIFT_LSL, 8'd0, 1'b0, 4'h6));
      // mode code three acts as rotated immediate; upper bits of b ignored
      pending_words.push_back(make_word(OP_TEQ, COND_AL, 32'h4000_0000, 32'hFFFF_FF81,
                                        MODE_ROT_IMM | MODE_REG_SHIFT, SHIFT_ROR, 8'd2,
                                        1'b1, 4'h0));
      pending_words.push_back(make_word(OP_CMP, COND_AL, 32'h5, 32'h5,
                                        MODE_IMM_SHIFT, SHIFT_LSL, 8'd0, 1'b0, 4'hF));
      pending_words.push_back(make_word(OP_CMN, COND_AL, 32'h8000_0000, 32'h8000_0000,
                                        MODE_IMM_SHIFT, SHIFT_LSL, 8'd0, 1'b1, 4'h0));
      // ROR #0 is RRX
      pending_words.push_back(make_word(OP_ORR, COND_AL, 32'h0, 32'h1,
                                        MODE_IMM_SHIFT, SHIFT_ROR, 8'd0, 1'b1, 4'h2));
      // immediate count keeps only its low five bits
      pending_words.push_back(make_word(OP_MOV, COND_AL, 32'h0, 32'hC000_0001,
                                        MODE_IMM_SHIFT, SHIFT_LSL, 8'hE1, 1'b1, 4'h0));
      // register shift by zero keeps operand and carry
      pending_words.push_back(make_word(OP_BIC, COND_AL, 32'hFFFF_FFFF, 32'h00FF_00FF,
                                        MODE_REG_SHIFT, SHIFT_LSL, 8'd0, 1'b1, 4'h2));
      pending_words.push_back(make_word(OP_MVN, COND_AL, 32'h0, 32'hFFFF_FFFF,
                                        MODE_REG_SHIFT, SHIFT_LSL, 8'd33, 1'b1, 4'h2));
      pending_words.push_back(make_word(OP_MOV, COND_AL, 32'h0, 32'h1,
                                        MODE_REG_SHIFT, SHIFT_LSL, 8'd32, 1'b1, 4'h0));
      pending_words.push_back(make_word(OP_MOV, COND_AL, 32'h0, 32'hFFFF_FFFF,
                                        MODE_REG_SHIFT, SHIFT_LSR, 8'd255, 1'b1, 4'h2));
      pending_words.push_back(make_word(OP_MOV, COND_AL, 32'h0, 32'h8000_0000,
                                        MODE_REG_SHIFT, SHIFT_ASR, 8'd40, 1'b1, 4'h0));
      // ROR by a nonzero multiple of 32: value kept, carry from bit 31
      pending_words.push_back(make_word(OP_MOV, COND_AL, 32'h0, 32'h8000_0001,
                                        MODE_REG_SHIFT, SHIFT_ROR, 8'd64, 1'b1, 4'h0));
      pending_words.push_back(make_word(OP_MOV, COND_AL, 32'h0, 32'h0000_0003,
                                        MODE_REG_SHIFT, SHIFT_ROR, 8'd255, 1'b1, 4'h0));
      // never, a failing EQ and a passing GT
      pending_words.push_back(make_word(OP_ADD, COND_NV, 32'h1, 32'h1,
                                        MODE_IMM_SHIFT, SHIFT_LSL, 8'd0, 1'b1, 4'hF));
      pending_words.push_back(make_word(OP_SUB, COND_EQ, 32'h1, 32'h1,
                                        MODE_IMM_SHIFT, SHIFT_LSL, 8'd0, 1'b1, 4'h0));
      pending_words.push_back(make_word(OP_ADD, COND_GT, 32'hFFFF_FFFF, 32'h1,
                                        MODE_IMM_SHIFT, SHIFT_LSL, 8'd0, 1'b1, 4'b1001));
      pending_words.push_back(make_word(OP_MOV, COND_AL, 32'h0, 32'hFFFF_FFFF,
                                        MODE_ROT_IMM, SHIFT_LSL, 8'd30, 1'b1, 4'h0));

      // Random words, condition AL about half the time so most execute
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         w.operation = alu_op_type'($urandom_range(0, 15));
         w.condition = ($urandom_range(0, 1) == 0) ? COND_AL
                                                   : cond_type'($urandom_range(0, 15));
         w.operand_a  = pick_operand();
         w.operand_b  = pick_operand();
         w.shift.mode = 2'($urandom_range(0, 3));
         w.shift.op   = shift_op_type'($urandom_range(0, 3));
         case ($urandom_range(0, 3))
            0:       w.shift.amount = 8'($urandom_range(0, 255));
            1:       w.shift.amount = 8'($urandom_range(30, 34));
            default: w.shift.amount = 8'($urandom_range(0, 31));
         endcase
         w.set_flags = $urandom_range(0, 3) != 0;
         w.flags_in  = 4'($urandom_range(0, 15));
         pending_words.push_back(w);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while ((pending_words.size() != 0 || expected_results.size() != 0) &&
             idle_cycles < WATCHDOG_LIMIT)
         @(negedge clock);

      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $error("watchdog: no word moved for %0d cycles, %0d words pending, %0d results due",
                idle_cycles, pending_words.size(), expected_results.size());
         $display("armv4t_data_processing_alu_tb: FAIL");
      end else begin
         repeat (DRAIN_CYCLES) @(negedge clock);
         $display("Covered %0d ALU operations and %0d result words, %0d failed a condition,",
                  words_sent, results_checked, cond_fail_count);
         $display("under bursty input and %0d long result-side hold-offs; %0d mismatches.",
                  long_holds, error_count);
         if (error_count == 0) begin
            $display("armv4t_data_processing_alu_tb: PASS");
         end else begin
            $display("armv4t_data_processing_alu_tb: FAIL");
         end
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/adpalu_pkg.sv
rtl/adpalu_if.sv
rtl/adpalu_shifter.sv
rtl/armv4t_data_processing_alu.sv
tb/armv4t_data_processing_alu_tb.sv
